[design/rses_pkg.sv]
`default_nettype none

package rses_pkg;

   // Instruction codes carried in the opcode field
   localparam logic [3:0] OP_CBZ  = 4'd0;
   localparam logic [3:0] OP_CBNZ = 4'd1;
   localparam logic [3:0] OP_ADDI = 4'd2;
   localparam logic [3:0] OP_SUBI = 4'd3;
   localparam logic [3:0] OP_ANDI = 4'd4;
   localparam logic [3:0] OP_ORRI = 4'd5;
   localparam logic [3:0] OP_EORI = 4'd6;
   localparam logic [3:0] OP_ADD  = 4'd7;
   localparam logic [3:0] OP_SUB  = 4'd8;
   localparam logic [3:0] OP_AND  = 4'd9;
   localparam logic [3:0] OP_ORR  = 4'd10;
   localparam logic [3:0] OP_EOR  = 4'd11;
   localparam logic [3:0] OP_LSR  = 4'd12;
   localparam logic [3:0] OP_LSL  = 4'd13;
   localparam logic [3:0] OP_LDUR = 4'd14;
   localparam logic [3:0] OP_STUR = 4'd15;

   // Item kinds on the request tuser bit
   localparam logic CMD_EXEC    = 1'b0;
   localparam logic CMD_PRELOAD = 1'b1;

   localparam logic [31:0] PC_RESET = 32'd64;

   localparam int REQ_TDATA_W = 168;
   localparam int RSP_TDATA_W = 200;

   // Result beat, first member in the highest bits
   typedef struct packed {
      logic [63:0] mem_write_value;
      logic [31:0] mem_write_address;
      logic        mem_write_valid;
      logic [63:0] reg_write_value;
      logic [4:0]  reg_write_index;
      logic        reg_write_valid;
      logic        branch_taken;
      logic [31:0] next_pc;
   } rses_rsp_type;

endpackage

`default_nettype wire

[design/risc_subset_execute_step_top.sv]
// Channel   Dir  Handshake             Payload
// req       in   req_tvalid/tready     tdata: decoded instruction or preload word, tuser: kind
// rsp       out  rsp_tvalid/tready     tdata: next PC, register write, memory write
// csr       in   csr_valid/ready       csr_wdata: start PC (also loads the PC)
//
// ALU ops, branches, stores and preloads: one beat per cycle unless rsp stalls, set by the
// register file read port (operands read at acceptance, results forwarded to the next beat).
// LDUR: the registered data memory read feeds write back; no new request is taken while the
// load sits in execute, only as it leaves write back. Reset: synchronous; afterwards a
// clearing pass zeroes all MEM_WORDS = 2**MEM_ADDR_BITS words while req_tready stays low.
// A stalled rsp beat holds in the output register; one further beat may be accepted.
`default_nettype none

module risc_subset_execute_step_top
   import rses_pkg::*;
#(
   parameter int MEM_ADDR_BITS = 10   // data memory holds 2**MEM_ADDR_BITS words, 4..16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // opcode, dest_reg, first_source_reg, second_source_reg, immediate,
   // branch_offset, preload_address, preload_value, 2 zero bits
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // command
   input  wire logic                   req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // next_pc, branch_taken, reg_write_valid, reg_write_index, reg_write_value,
   // mem_write_valid, mem_write_address, mem_write_value
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [31:0]            csr_wdata
);

   localparam int MEM_WORDS = 1 << MEM_ADDR_BITS;

   // Request fields
   logic [3:0]  req_opcode;
   logic [4:0]  req_rd;
   logic [4:0]  req_rn;
   logic [4:0]  req_rm;
   logic [31:0] req_imm;
   logic [18:0] req_off;
   logic [31:0] req_paddr;
   logic [63:0] req_pval;
   logic        req_fire;
   logic [4:0]  rf_rb_addr;

   assign req_opcode = req_tdata[3:0];
   assign req_rd     = req_tdata[8:4];
   assign req_rn     = req_tdata[13:9];
   assign req_rm     = req_tdata[18:14];
   assign req_imm    = req_tdata[50:19];
   assign req_off    = req_tdata[69:51];
   assign req_paddr  = req_tdata[101:70];
   assign req_pval   = req_tdata[165:102];
   assign req_fire   = req_tvalid & req_tready;
   // a store reads its data register on the second port
   assign rf_rb_addr = (req_opcode == OP_STUR) ? req_rd : req_rm;

   // Register file and its write port
   logic [63:0] rf_mem [32];
   logic [31:0] rf_ok_ff;
   logic        rf_we;
   logic [4:0]  rf_wa;
   logic [63:0] rf_wd;
   logic [63:0] rf_rda_ff, rf_rdb_ff;
   logic        ok_a_ff, ok_b_ff, fwd_a_ff, fwd_b_ff;
   logic [63:0] fwd_val_ff;

   // Execute stage
   logic        x_vld_ff;
   logic        x_cmd_ff;
   logic [3:0]  x_op_ff;
   logic [4:0]  x_rd_ff;
   logic [31:0] x_imm_ff;
   logic [18:0] x_off_ff;
   logic [31:0] x_paddr_ff;
   logic [63:0] x_pval_ff;

   // Load write-back stage
   logic        m_vld_ff;
   logic [4:0]  m_rd_ff;
   logic [31:0] m_pc_ff;

   logic [31:0] pc_ff;
   logic        rsp_valid_ff;
   rses_rsp_type rsp_data_ff;

   // Data memory and clearing pass
   logic [63:0]              dmem [MEM_WORDS];
   logic [63:0]              dm_rd_ff;
   logic                     dm_we;
   logic [MEM_ADDR_BITS-1:0] dm_wa;
   logic [63:0]              dm_wd;
   logic                     clr_busy_ff;
   logic [MEM_ADDR_BITS-1:0] clr_idx_ff;

   // Execute datapath
   logic [63:0]              opa, opb, imm64, sum_imm, alu;
   logic [31:0]              off32, x_next_pc;
   logic                     x_is_load, x_taken, x_rw, x_mw, x_go, m_go, o_free;
   logic [MEM_ADDR_BITS-1:0] x_idx;
   rses_rsp_type             x_rsp, m_rsp;

   // Apply forwarding, then the register valid bit (unwritten reads as zero)
   assign opa = fwd_a_ff ? fwd_val_ff : (ok_a_ff ? rf_rda_ff : 64'd0);
   assign opb = fwd_b_ff ? fwd_val_ff : (ok_b_ff ? rf_rdb_ff : 64'd0);
   assign imm64   = {{32{x_imm_ff[31]}}, x_imm_ff};
   assign sum_imm = opa + imm64;
   assign off32   = {{11{x_off_ff[18]}}, x_off_ff, 2'b00};

   always_comb begin
      unique case (x_op_ff)
         OP_ADDI: alu = sum_imm;
         OP_SUBI: alu = opa - imm64;
         OP_ANDI: alu = opa & imm64;
         OP_ORRI: alu = opa | imm64;
         OP_EORI: alu = opa ^ imm64;
         OP_ADD:  alu = opa + opb;
         OP_SUB:  alu = opa - opb;
         OP_AND:  alu = opa & opb;
         OP_ORR:  alu = opa | opb;
         OP_EOR:  alu = opa ^ opb;
         OP_LSR:  alu = opa >> opb[4:0];
         OP_LSL:  alu = opa << opb[4:0];
         default: alu = 64'd0;
      endcase
   end

   assign x_is_load = (x_cmd_ff == CMD_EXEC) && (x_op_ff == OP_LDUR);
   assign x_taken   = (x_cmd_ff == CMD_EXEC) &&
                      (((x_op_ff == OP_CBZ) && (opa == 64'd0)) ||
                       ((x_op_ff == OP_CBNZ) && (opa != 64'd0)));
   assign x_rw      = (x_cmd_ff == CMD_EXEC) && (x_op_ff != OP_CBZ) &&
                      (x_op_ff != OP_CBNZ) && (x_op_ff != OP_LDUR) && (x_op_ff != OP_STUR);
   assign x_mw      = (x_cmd_ff == CMD_PRELOAD) || (x_op_ff == OP_STUR);
   assign x_idx     = (x_cmd_ff == CMD_PRELOAD) ? x_paddr_ff[MEM_ADDR_BITS+1:2]
                                                : sum_imm[MEM_ADDR_BITS+1:2];

   always_comb begin
      priority if (x_cmd_ff == CMD_PRELOAD) x_next_pc = pc_ff;
      else if (x_taken)                    x_next_pc = pc_ff + off32;
      else                                 x_next_pc = pc_ff + 32'd4;
   end

   always_comb begin
      x_rsp                   = '0;
      x_rsp.next_pc           = x_next_pc;
      x_rsp.branch_taken      = x_taken;
      x_rsp.reg_write_valid   = x_rw;
      x_rsp.reg_write_index   = x_rw ? x_rd_ff : 5'd0;
      x_rsp.reg_write_value   = x_rw ? alu : 64'd0;
      x_rsp.mem_write_valid   = x_mw;
      x_rsp.mem_write_address = (x_cmd_ff == CMD_PRELOAD) ? x_paddr_ff :
                                (x_mw ? sum_imm[31:0] : 32'd0);
      x_rsp.mem_write_value   = (x_cmd_ff == CMD_PRELOAD) ? x_pval_ff :
                                (x_mw ? opb : 64'd0);
   end

   always_comb begin
      m_rsp                 = '0;
      m_rsp.next_pc         = m_pc_ff;
      m_rsp.reg_write_valid = 1'b1;
      m_rsp.reg_write_index = m_rd_ff;
      m_rsp.reg_write_value = dm_rd_ff;
   end

   // Flow control: a load hands over to write back, everything else to the output register
   assign o_free = ~rsp_valid_ff | rsp_tready;
   assign m_go   = m_vld_ff & o_free;
   assign x_go   = x_vld_ff & (x_is_load ? (~m_vld_ff | m_go) : (o_free & ~m_vld_ff));
   // hold new beats while a load has not yet written its register back
   assign req_tready = ~clr_busy_ff & (~x_vld_ff | (x_go & ~x_is_load)) &
                       (~m_vld_ff | m_go);
   assign csr_ready  = 1'b1;

   assign rf_we = m_go | (x_go & x_rw);
   assign rf_wa = m_go ? m_rd_ff : x_rd_ff;
   assign rf_wd = m_go ? dm_rd_ff : alu;

   // Register file: two registered read ports, one write port
   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_mem[rf_wa] <= rf_wd;
      end
      if (req_fire) begin
         rf_rda_ff <= rf_mem[req_rn];
         rf_rdb_ff <= rf_mem[rf_rb_addr];
      end
   end

   // Operand bypass and valid bits, captured with the read
   always_ff @(posedge clock) begin
      if (req_fire) begin
         ok_a_ff    <= rf_ok_ff[req_rn];
         ok_b_ff    <= rf_ok_ff[rf_rb_addr];
         fwd_a_ff   <= rf_we && (rf_wa == req_rn);
         fwd_b_ff   <= rf_we && (rf_wa == rf_rb_addr);
         fwd_val_ff <= rf_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_ok_ff <= '0;
      end else if (rf_we) begin
         rf_ok_ff[rf_wa] <= 1'b1;
      end
   end

   // Execute stage payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         x_cmd_ff   <= req_tuser;
         x_op_ff    <= req_opcode;
         x_rd_ff    <= req_rd;
         x_imm_ff   <= req_imm;
         x_off_ff   <= req_off;
         x_paddr_ff <= req_paddr;
         x_pval_ff  <= req_pval;
      end
      if (x_go && x_is_load) begin
         m_rd_ff <= x_rd_ff;
         m_pc_ff <= x_next_pc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_vld_ff <= 1'b0;
         m_vld_ff <= 1'b0;
      end else begin
         priority if (req_fire) x_vld_ff <= 1'b1;
         else if (x_go)         x_vld_ff <= 1'b0;
         priority if (x_go && x_is_load) m_vld_ff <= 1'b1;
         else if (m_go)                  m_vld_ff <= 1'b0;
      end
   end

   // Program counter; a start PC write loads it at once
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_RESET;
      end else if (csr_valid && csr_ready) begin
         pc_ff <= csr_wdata;
      end else if (x_go && (x_cmd_ff == CMD_EXEC)) begin
         pc_ff <= x_next_pc;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (m_go || (x_go && !x_is_load)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (m_go) begin
         rsp_data_ff <= m_rsp;
      end else if (x_go && !x_is_load) begin
         rsp_data_ff <= x_rsp;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Data memory: one write port, one registered read port
   assign dm_we = clr_busy_ff | (x_go & x_mw);
   assign dm_wa = clr_busy_ff ? clr_idx_ff : x_idx;
   assign dm_wd = clr_busy_ff ? 64'd0 : (x_cmd_ff == CMD_PRELOAD) ? x_pval_ff : opb;

   always_ff @(posedge clock) begin
      if (dm_we) begin
         dmem[dm_wa] <= dm_wd;
      end
      if (x_go && x_is_load) begin
         dm_rd_ff <= dmem[x_idx];
      end
   end

   // Clearing pass: sweep every word after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else if (clr_busy_ff) begin
         if (clr_idx_ff == MEM_ADDR_BITS'(MEM_WORDS - 1)) begin
            clr_busy_ff <= 1'b0;
         end
         clr_idx_ff <= clr_idx_ff + 1'b1;
      end
   end

endmodule

`default_nettype wire

[design/rses_checker.sv]
`default_nettype none

module rses_checker
   import rses_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata
);

   rses_rsp_type rsp;

   assign rsp = rsp_tdata;

   // Memory clearing keeps the request side closed straight after reset
   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !(req_tvalid && req_tready))
      else $error("request accepted during memory clearing");

   a_reg_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp.reg_write_valid) |->
         (rsp.reg_write_index == 5'd0) && (rsp.reg_write_value == 64'd0))
      else $error("register write fields set without a register write");

   a_mem_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp.mem_write_valid) |->
         (rsp.mem_write_address == 32'd0) && (rsp.mem_write_value == 64'd0))
      else $error("memory write fields set without a memory write");

   a_branch_no_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp.branch_taken) |->
         !rsp.reg_write_valid && !rsp.mem_write_valid)
      else $error("taken branch reports a write");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

endmodule

bind risc_subset_execute_step_top rses_checker u_rses_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
